@@ design/bbe_pkg.sv @@
// Shared constants, types and control structs of the edge-normalized box blur.
package bbe_pkg;

    localparam int RADIUS     = 1;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SIZE_W     = 11;
    localparam int RESET_SIZE = 1024;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int LIN_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int MUL_W   = DIM_W + DIM_W + 1;

    localparam int HIST_DEPTH = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    // raster index modulo ring depth via truncated reciprocal
    localparam int          MOD_SHIFT = LIN_W + ADDR_W;
    localparam int          RECIP_W   = MOD_SHIFT - ADDR_W + 1;
    localparam logic [63:0] MOD_RECIP = (64'd1 << MOD_SHIFT) / 64'(HIST_DEPTH);
    localparam int          PROD_W    = LIN_W + RECIP_W;
    localparam int          QUO_W     = LIN_W - ADDR_W + 1;

    localparam int NB_SIDE = 2 * RADIUS + 1;
    localparam int NB_CNT  = NB_SIDE * NB_SIDE;
    localparam int SLOT_W  = (NB_SIDE > 1) ? $clog2(NB_SIDE) : 1;
    localparam int CNT_W   = $clog2(NB_CNT + 1);
    localparam int SUM_W   = $clog2(NB_CNT * 255 + 1);
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = CNT_W + 1;
    localparam int REM_W   = DEN_W;
    localparam int QUOT_W  = CH_W;

    typedef struct packed {
        logic             valid;
        logic             write;
        logic             inb;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] data;
    } hist_req_t;

    typedef struct packed {
        logic             valid;
        logic             inb;
        logic             last;
        logic [PIX_W-1:0] data;
    } hist_rsp_t;

    typedef struct packed {
        logic [REM_W-1:0]  p;
        logic [QUOT_W-1:0] nlow;
        logic [QUOT_W-1:0] q;
    } div_lane_t;

    typedef struct packed {
        logic                         valid;
        logic                         zero;
        logic [DEN_W-1:0]             d;
        div_lane_t [NUM_CH-1:0]       lane;
    } div_item_t;

endpackage

@@ design/bbe_if.sv @@
// Handshake channels of the blur: pixel input, result output, register writes.
interface bbe_pix_if import bbe_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, func, in_red, in_green, in_blue, input ready);
    modport sink (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface bbe_res_if import bbe_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last_pixel;

    modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
    modport sink (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

interface bbe_cfg_if import bbe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/bbe_hist.sv @@
// Pixel history ring: raster position to ring address pipeline plus the memory.
module bbe_hist import bbe_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] w,
    input  hist_req_t        req,
    output hist_rsp_t        rsp
);

    logic                s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic                s0_write_reg, s1_write_reg, s2_write_reg;
    logic                s0_inb_reg, s1_inb_reg, s2_inb_reg;
    logic                s0_last_reg, s1_last_reg, s2_last_reg;
    logic [PIX_W-1:0]    s0_data_reg, s1_data_reg, s2_data_reg;
    logic [LIN_W-1:0]    s0_lin_reg, s1_lin_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [ADDR_W:0]     s2_rem_reg;

    logic [LIN_W-1:0]    lin_next;
    logic [QUO_W-1:0]    est;
    logic [LIN_W-1:0]    est_mul;
    logic [ADDR_W-1:0]   addr;

    logic                rd_valid_reg, rd_inb_reg, rd_last_reg;
    logic [PIX_W-1:0]    rd_data_reg;
    logic [PIX_W-1:0]    mem [HIST_DEPTH];

    assign lin_next = LIN_W'(MUL_W'(req.row) * MUL_W'(w) + MUL_W'(req.col));
    assign est      = QUO_W'(s1_prod_reg >> MOD_SHIFT);
    assign est_mul  = LIN_W'(LIN_W'(est) * LIN_W'(HIST_DEPTH));

    // estimate may be one low, so one compare and subtract finishes the modulo
    always_comb
    begin
        if (s2_rem_reg >= (ADDR_W+1)'(HIST_DEPTH))
            addr = ADDR_W'(s2_rem_reg - (ADDR_W+1)'(HIST_DEPTH));
        else
            addr = ADDR_W'(s2_rem_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= req.valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            rd_valid_reg <= s2_valid_reg && !s2_write_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_write_reg <= req.write;
        s0_inb_reg   <= req.inb;
        s0_last_reg  <= req.last;
        s0_data_reg  <= req.data;
        s0_lin_reg   <= lin_next;

        s1_write_reg <= s0_write_reg;
        s1_inb_reg   <= s0_inb_reg;
        s1_last_reg  <= s0_last_reg;
        s1_data_reg  <= s0_data_reg;
        s1_lin_reg   <= s0_lin_reg;
        s1_prod_reg  <= PROD_W'(s0_lin_reg) * PROD_W'(MOD_RECIP[RECIP_W-1:0]);

        s2_write_reg <= s1_write_reg;
        s2_inb_reg   <= s1_inb_reg;
        s2_last_reg  <= s1_last_reg;
        s2_data_reg  <= s1_data_reg;
        s2_rem_reg   <= (ADDR_W+1)'(s1_lin_reg - est_mul);

        rd_inb_reg   <= s2_inb_reg;
        rd_last_reg  <= s2_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_write_reg)
            mem[addr] <= s2_data_reg;
        rd_data_reg <= mem[addr];
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.inb   = rd_inb_reg;
    assign rsp.last  = rd_last_reg;
    assign rsp.data  = rd_data_reg;

endmodule

@@ design/bbe_div_cell.sv @@
// One cell of the rounding divider chain: resolves one quotient bit per lane.
module bbe_div_cell import bbe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  div_item_t din,
    output div_item_t dout
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic [REM_W:0] trial [NUM_CH];

    always_comb
    begin
        item_next = din;
        for (int k = 0; k < NUM_CH; k++)
        begin
            trial[k] = {din.lane[k].p, din.lane[k].nlow[QUOT_W-1]};
            item_next.lane[k].nlow = din.lane[k].nlow << 1;
            if (trial[k] >= {1'b0, din.d})
            begin
                item_next.lane[k].p = REM_W'(trial[k] - {1'b0, din.d});
                item_next.lane[k].q = {din.lane[k].q[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                item_next.lane[k].p = REM_W'(trial[k]);
                item_next.lane[k].q = {din.lane[k].q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    always_comb
    begin
        dout       = item_reg;
        dout.valid = valid_reg;
    end

endmodule

@@ design/box_blur_edge_normalized.sv @@
// An accepted item passes the ring address pipe, the 3x3 neighbor reads and the divider to give its result.
// Items are handled one at a time: a new item is accepted only once the block is back in idle.
// A result still waiting on the output holds the next item at the divider load.
// The nine neighbor reads share the single read port; the divider is an 8-cell chain.
// Reset (rst_n low, async) clears the frame counters and sets both sizes to 1024.
// History memory is not cleared; entries are written before they are read.
module box_blur_edge_normalized import bbe_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bbe_pix_if.sink   pix,
    bbe_res_if.source res,
    bbe_cfg_if.sink   cfg
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INLIN  = 3'd1;
    localparam logic [2:0] ST_OUTLIN = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_ISSUE  = 3'd4;
    localparam logic [2:0] ST_GATHER = 3'd5;
    localparam logic [2:0] ST_LOAD   = 3'd6;
    localparam logic [2:0] ST_DRAIN  = 3'd7;

    logic [2:0]        state_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic              in_done_reg;
    logic [LIN_W-1:0]  in_lin_reg, out_lin_reg;
    logic [SLOT_W-1:0] dr_reg, dc_reg;
    logic [SUM_W-1:0]  sum_reg [NUM_CH];
    logic [CNT_W-1:0]  cnt_reg;

    logic              res_valid_reg, res_last_reg;
    logic [CH_W-1:0]   res_ch_reg [NUM_CH];

    logic [DIM_W-1:0]  w, h;
    logic              pix_acc, wr_pix, adv, load_res, out_last, slot_last;
    logic [LIN_W+1:0]  threshold;
    logic [DIM_W+1:0]  nb_row, nb_col;
    logic              nb_inb;
    hist_req_t         req;
    hist_rsp_t         rsp;
    div_item_t         chain [QUOT_W+1];
    div_item_t         tail;
    logic [NUM_W-1:0]  num [NUM_CH];

    // sizes clamp to 1..max
    always_comb
    begin
        if (width_reg == '0)
            w = DIM_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w = DIM_W'(MAX_WIDTH);
        else
            w = DIM_W'(width_reg);
        if (height_reg == '0)
            h = DIM_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h = DIM_W'(MAX_HEIGHT);
        else
            h = DIM_W'(height_reg);
    end

    assign cfg.ready = 1'b1;
    assign pix.ready = (state_reg == ST_IDLE);
    assign pix_acc   = pix.valid && pix.ready;
    assign wr_pix    = pix_acc && !pix.func && !in_done_reg;

    assign threshold = (LIN_W+2)'(out_lin_reg) + (LIN_W+2)'(RADIUS) * (LIN_W+2)'(w)
                     + (LIN_W+2)'(RADIUS + 1);

    assign nb_row = (DIM_W+2)'(out_row_reg) + (DIM_W+2)'(dr_reg) - (DIM_W+2)'(RADIUS);
    assign nb_col = (DIM_W+2)'(out_col_reg) + (DIM_W+2)'(dc_reg) - (DIM_W+2)'(RADIUS);
    assign nb_inb = !nb_row[DIM_W+1] && (nb_row < (DIM_W+2)'(h))
                 && !nb_col[DIM_W+1] && (nb_col < (DIM_W+2)'(w));
    assign slot_last = (32'(dr_reg) == NB_SIDE - 1) && (32'(dc_reg) == NB_SIDE - 1);

    always_comb
    begin
        req       = '0;
        req.data  = {pix.in_blue, pix.in_green, pix.in_red};
        if (state_reg == ST_ISSUE)
        begin
            req.valid = 1'b1;
            req.inb   = nb_inb;
            req.last  = slot_last;
            req.row   = nb_inb ? ROW_W'(nb_row) : '0;
            req.col   = nb_inb ? COL_W'(nb_col) : '0;
        end
        else
        begin
            req.valid = wr_pix;
            req.write = 1'b1;
            req.row   = in_row_reg;
            req.col   = in_col_reg;
        end
    end

    bbe_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .w     (w),
        .req   (req),
        .rsp   (rsp)
    );

    // divider input: quotient of (2*sum + cnt) / (2*cnt)
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = (state_reg == ST_LOAD);
        chain[0].zero  = (cnt_reg == '0);
        chain[0].d     = DEN_W'({cnt_reg, 1'b0});
        for (int k = 0; k < NUM_CH; k++)
        begin
            num[k] = NUM_W'({sum_reg[k], 1'b0}) + NUM_W'(cnt_reg);
            chain[0].lane[k].p    = REM_W'(num[k] >> QUOT_W);
            chain[0].lane[k].nlow = num[k][QUOT_W-1:0];
            chain[0].lane[k].q    = '0;
        end
    end

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_div
        bbe_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    assign tail     = chain[QUOT_W];
    assign adv      = !(res_valid_reg && !res.ready);
    assign load_res = tail.valid && adv;
    assign out_last = ((DIM_W+1)'(out_row_reg) + 1'b1 >= (DIM_W+1)'(h))
                   && ((DIM_W+1)'(out_col_reg) + 1'b1 >= (DIM_W+1)'(w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(RESET_SIZE);
            height_reg <= SIZE_W'(RESET_SIZE);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WIDTH:  width_reg  <= cfg.data;
                CFG_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            in_done_reg   <= 1'b0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pix_acc)
                        state_reg <= ST_INLIN;
                    if (wr_pix)
                    begin
                        if ((DIM_W+1)'(in_col_reg) + 1'b1 >= (DIM_W+1)'(w))
                        begin
                            in_col_reg <= '0;
                            if ((DIM_W+1)'(in_row_reg) + 1'b1 >= (DIM_W+1)'(h))
                            begin
                                in_row_reg  <= '0;
                                in_done_reg <= 1'b1;
                            end
                            else
                                in_row_reg <= in_row_reg + 1'b1;
                        end
                        else
                            in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                ST_INLIN:  state_reg <= ST_OUTLIN;
                ST_OUTLIN: state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    dr_reg <= '0;
                    dc_reg <= '0;
                    if (!in_done_reg && ((LIN_W+2)'(in_lin_reg) < threshold))
                        state_reg <= ST_IDLE;
                    else
                        state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    if (32'(dc_reg) == NB_SIDE - 1)
                    begin
                        dc_reg <= '0;
                        dr_reg <= dr_reg + 1'b1;
                    end
                    else
                        dc_reg <= dc_reg + 1'b1;
                    if (slot_last)
                        state_reg <= ST_GATHER;
                end
                ST_GATHER:
                begin
                    if (rsp.valid && rsp.last)
                        state_reg <= ST_LOAD;
                end
                // hold the load until the divider chain moves
                ST_LOAD:
                begin
                    if (adv)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (load_res)
                    begin
                        state_reg <= ST_IDLE;
                        if (out_last)
                        begin
                            out_row_reg <= '0;
                            out_col_reg <= '0;
                            in_row_reg  <= '0;
                            in_col_reg  <= '0;
                            in_done_reg <= 1'b0;
                        end
                        else if ((DIM_W+1)'(out_col_reg) + 1'b1 >= (DIM_W+1)'(w))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end
                        else
                            out_col_reg <= out_col_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        in_lin_reg  <= LIN_W'(MUL_W'(in_row_reg) * MUL_W'(w) + MUL_W'(in_col_reg));
        out_lin_reg <= LIN_W'(MUL_W'(out_row_reg) * MUL_W'(w) + MUL_W'(out_col_reg));

        if (state_reg == ST_CHECK)
        begin
            cnt_reg <= '0;
            for (int k = 0; k < NUM_CH; k++)
                sum_reg[k] <= '0;
        end
        else if (rsp.valid && rsp.inb)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            for (int k = 0; k < NUM_CH; k++)
                sum_reg[k] <= sum_reg[k] + SUM_W'(rsp.data[k*CH_W +: CH_W]);
        end

        if (load_res)
        begin
            res_last_reg <= out_last;
            for (int k = 0; k < NUM_CH; k++)
                res_ch_reg[k] <= tail.zero ? '0 : tail.lane[k].q;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.out_red    = res_ch_reg[0];
    assign res.out_green  = res_ch_reg[1];
    assign res.out_blue   = res_ch_reg[2];
    assign res.last_pixel = res_last_reg;

endmodule
